// ===== rtl/core/sfc_pkg.sv =====
// shared types, constants and codes of the scanf format checker
package sfc_pkg;

    localparam int MAX_FORMAT_LEN = 1024;
    localparam int COUNT_LIMIT    = (MAX_FORMAT_LEN < 2047) ? MAX_FORMAT_LEN : 2047;

    localparam int CHAR_W  = 21;
    localparam int CNT_W   = 12;
    localparam int MASK_W  = 12;
    localparam int STAT_W  = 2;

    localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_LIMIT);
    localparam logic signed [CNT_W-1:0] CNT_MIN = -CNT_W'(COUNT_LIMIT);

    // kind mask bits
    localparam logic [MASK_W-1:0] KM_C     = MASK_W'(1) << 0;
    localparam logic [MASK_W-1:0] KM_DI    = MASK_W'(1) << 1;
    localparam logic [MASK_W-1:0] KM_E     = MASK_W'(1) << 2;
    localparam logic [MASK_W-1:0] KM_G     = MASK_W'(1) << 3;
    localparam logic [MASK_W-1:0] KM_FN    = MASK_W'(1) << 4;
    localparam logic [MASK_W-1:0] KM_O     = MASK_W'(1) << 5;
    localparam logic [MASK_W-1:0] KM_SB    = MASK_W'(1) << 6;
    localparam logic [MASK_W-1:0] KM_X     = MASK_W'(1) << 7;
    localparam logic [MASK_W-1:0] KM_U     = MASK_W'(1) << 8;
    localparam logic [MASK_W-1:0] KM_SHORT = MASK_W'(1) << 9;
    localparam logic [MASK_W-1:0] KM_PLAIN = MASK_W'(1) << 10;
    localparam logic [MASK_W-1:0] KM_LONG  = MASK_W'(1) << 11;

    typedef enum logic [4:0] {
        CL_NONE,
        CL_PCT,
        CL_DIGIT,
        CL_STAR,
        CL_H,
        CL_L,
        CL_C,
        CL_U,
        CL_DI,
        CL_E,
        CL_G,
        CL_N,
        CL_F,
        CL_O,
        CL_S,
        CL_BRACKET,
        CL_CLOSE,
        CL_X,
        CL_OTHER
    } cls_t;

    typedef enum logic [2:0] {
        PH_LITERAL,
        PH_AFTER_PCT,
        PH_WIDTH,
        PH_TYPE,
        PH_BRACKET
    } phase_t;

    typedef enum logic [1:0] {
        MOD_NONE,
        MOD_SHORT,
        MOD_LONG
    } mod_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_BAD,
        ST_INCOMPLETE
    } status_t;

    typedef struct packed {
        cls_t cls;
        logic last;
    } item_t;

endpackage

// ===== rtl/core/sfc_if.sv =====
// channel interfaces for format characters and check results
interface sfc_in_if;
    import sfc_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              has_char;
    logic              is_last;

    modport source (output valid, output char_code, output has_char, output is_last,
                    input ready);
    modport sink   (input valid, input char_code, input has_char, input is_last,
                    output ready);
endinterface

interface sfc_out_if;
    import sfc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [CNT_W-1:0]  conversion_count;
    logic [MASK_W-1:0]        kind_mask;

    modport source (output valid, output status, output conversion_count,
                    output kind_mask, input ready);
    modport sink   (input valid, input status, input conversion_count,
                    input kind_mask, output ready);
endinterface

// ===== rtl/core/scanf_format_checker.sv =====
// top level of the scanf format string checker
// takes one character per cycle unless the engine holds a last character behind an unread result;
// a result is valid once its last character has passed the queue write at the accepting edge and
// then the engine's state update into the result register
// rst_n clears the walk state, the queue and the result valid at once
module scanf_format_checker (
    input  logic       clk,
    input  logic       rst_n,
    sfc_in_if.sink     req,
    sfc_out_if.source  rsp
);
    import sfc_pkg::*;

    logic   push_valid;
    item_t  push_item;
    logic   push_ready;
    logic   pop_valid;
    item_t  pop_item;
    logic   pop_ready;

    sfc_classify u_classify (
        .req        (req),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    sfc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    sfc_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .rsp        (rsp)
    );

endmodule

// ===== rtl/core/sfc_classify.sv =====
// front end: takes characters and sorts them into classes
module sfc_classify (
    sfc_in_if.sink          req,
    output logic            push_valid,
    output sfc_pkg::item_t  push_item,
    input  logic            push_ready
);
    import sfc_pkg::*;

    localparam logic [CHAR_W-1:0] CH_PCT   = CHAR_W'('h25);
    localparam logic [CHAR_W-1:0] CH_STAR  = CHAR_W'('h2a);
    localparam logic [CHAR_W-1:0] CH_0     = CHAR_W'('h30);
    localparam logic [CHAR_W-1:0] CH_9     = CHAR_W'('h39);
    localparam logic [CHAR_W-1:0] CH_BIG_E = CHAR_W'('h45);
    localparam logic [CHAR_W-1:0] CH_BIG_G = CHAR_W'('h47);
    localparam logic [CHAR_W-1:0] CH_BIG_L = CHAR_W'('h4c);
    localparam logic [CHAR_W-1:0] CH_BIG_X = CHAR_W'('h58);
    localparam logic [CHAR_W-1:0] CH_LBR   = CHAR_W'('h5b);
    localparam logic [CHAR_W-1:0] CH_RBR   = CHAR_W'('h5d);
    localparam logic [CHAR_W-1:0] CH_C     = CHAR_W'('h63);
    localparam logic [CHAR_W-1:0] CH_D     = CHAR_W'('h64);
    localparam logic [CHAR_W-1:0] CH_E     = CHAR_W'('h65);
    localparam logic [CHAR_W-1:0] CH_F     = CHAR_W'('h66);
    localparam logic [CHAR_W-1:0] CH_G     = CHAR_W'('h67);
    localparam logic [CHAR_W-1:0] CH_H     = CHAR_W'('h68);
    localparam logic [CHAR_W-1:0] CH_I     = CHAR_W'('h69);
    localparam logic [CHAR_W-1:0] CH_L     = CHAR_W'('h6c);
    localparam logic [CHAR_W-1:0] CH_N     = CHAR_W'('h6e);
    localparam logic [CHAR_W-1:0] CH_O     = CHAR_W'('h6f);
    localparam logic [CHAR_W-1:0] CH_S     = CHAR_W'('h73);
    localparam logic [CHAR_W-1:0] CH_U     = CHAR_W'('h75);
    localparam logic [CHAR_W-1:0] CH_X     = CHAR_W'('h78);

    cls_t cls;

    always_comb
    begin
        if (!req.has_char || req.char_code == '0)
        begin
            cls = CL_NONE;
        end
        else if (req.char_code >= CH_0 && req.char_code <= CH_9)
        begin
            cls = CL_DIGIT;
        end
        else
        begin
            case (req.char_code)
                CH_PCT:           cls = CL_PCT;
                CH_STAR:          cls = CL_STAR;
                CH_H:             cls = CL_H;
                CH_L, CH_BIG_L:   cls = CL_L;
                CH_C:             cls = CL_C;
                CH_U:             cls = CL_U;
                CH_D, CH_I:       cls = CL_DI;
                CH_E, CH_BIG_E:   cls = CL_E;
                CH_G, CH_BIG_G:   cls = CL_G;
                CH_N:             cls = CL_N;
                CH_F:             cls = CL_F;
                CH_O:             cls = CL_O;
                CH_S:             cls = CL_S;
                CH_LBR:           cls = CL_BRACKET;
                CH_RBR:           cls = CL_CLOSE;
                CH_X, CH_BIG_X:   cls = CL_X;
                default:          cls = CL_OTHER;
            endcase
        end
    end

    assign push_valid     = req.valid;
    assign push_item.cls  = cls;
    assign push_item.last = req.is_last;
    assign req.ready      = push_ready;

endmodule

// ===== rtl/core/sfc_queue.sv =====
// two-entry queue between classifier and engine
module sfc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  sfc_pkg::item_t  push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output sfc_pkg::item_t  pop_item,
    input  logic            pop_ready
);
    import sfc_pkg::*;

    item_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/sfc_engine.sv =====
// back end: walks the format state and registers the result
module sfc_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    input  sfc_pkg::item_t  pop_item,
    output logic            pop_ready,
    sfc_out_if.source       rsp
);
    import sfc_pkg::*;

    typedef struct packed {
        logic              err;
        logic [MASK_W-1:0] bits;
        logic              dec;
        logic              brk;
    } conv_t;

    function automatic conv_t conv_decode(input cls_t cls, input logic any_mod,
                                          input logic short_mod);
        conv_t r;
        r = '0;
        case (cls)
            CL_C:
            begin
                if (any_mod) r.err = 1'b1;
                else         r.bits = KM_C;
            end
            CL_U:  r.bits = KM_U;
            CL_DI: r.bits = KM_DI;
            CL_E:
            begin
                if (short_mod) r.err = 1'b1;
                else           r.bits = KM_E;
            end
            CL_G:
            begin
                if (short_mod) r.err = 1'b1;
                else           r.bits = KM_G;
            end
            CL_N:
            begin
                r.dec = 1'b1;
                if (short_mod) r.err = 1'b1;
                else           r.bits = KM_FN;
            end
            CL_F:
            begin
                if (short_mod) r.err = 1'b1;
                else           r.bits = KM_FN;
            end
            CL_O:  r.bits = KM_O;
            CL_S:
            begin
                if (short_mod) r.err = 1'b1;
                else           r.bits = KM_SB;
            end
            CL_BRACKET:
            begin
                if (any_mod)
                begin
                    r.err = 1'b1;
                end
                else
                begin
                    r.bits = KM_SB;
                    r.brk  = 1'b1;
                end
            end
            CL_X:  r.bits = KM_X;
            default: r.err = 1'b1;
        endcase
        return r;
    endfunction

    phase_t                  phase_reg;
    phase_t                  phase_next;
    mod_t                    mod_reg;
    mod_t                    mod_next;
    logic signed [CNT_W-1:0] cnt_reg;
    logic signed [CNT_W-1:0] cnt_next;
    logic [MASK_W-1:0]       mask_reg;
    logic [MASK_W-1:0]       mask_next;
    logic                    err_reg;
    logic                    err_next;

    phase_t                  step_phase;
    mod_t                    step_mod;
    logic signed [CNT_W-1:0] step_cnt;
    logic [MASK_W-1:0]       step_mask;
    logic                    step_err;
    logic                    cnt_up;
    logic                    cnt_down;
    conv_t                   conv;
    logic                    use_conv;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    status_t                 out_status_reg;
    status_t                 out_status_next;
    logic signed [CNT_W-1:0] out_cnt_reg;
    logic signed [CNT_W-1:0] out_cnt_next;
    logic [MASK_W-1:0]       out_mask_reg;
    logic [MASK_W-1:0]       out_mask_next;

    logic                    fire;

    assign pop_ready = !pop_item.last || !out_valid_reg || rsp.ready;
    assign fire      = pop_valid && pop_ready;

    // one character of the format walk
    always_comb
    begin
        step_phase = phase_reg;
        step_mod   = mod_reg;
        step_mask  = mask_reg;
        step_err   = err_reg;
        cnt_up     = 1'b0;
        cnt_down   = 1'b0;
        use_conv   = 1'b0;
        conv       = conv_decode(pop_item.cls, 1'b0, 1'b0);
        if (pop_item.cls != CL_NONE && !err_reg)
        begin
            case (phase_reg)
                PH_LITERAL:
                begin
                    if (pop_item.cls == CL_PCT)
                    begin
                        cnt_up     = 1'b1;
                        step_phase = PH_AFTER_PCT;
                    end
                end
                PH_BRACKET:
                begin
                    if (pop_item.cls == CL_CLOSE) step_phase = PH_LITERAL;
                end
                PH_TYPE:
                begin
                    conv     = conv_decode(pop_item.cls, mod_reg != MOD_NONE,
                                           mod_reg == MOD_SHORT);
                    use_conv = 1'b1;
                end
                PH_AFTER_PCT, PH_WIDTH:
                begin
                    if (pop_item.cls == CL_DIGIT)
                    begin
                        step_phase = PH_WIDTH;
                    end
                    else if (pop_item.cls == CL_STAR && phase_reg == PH_AFTER_PCT)
                    begin
                        cnt_down   = 1'b1;
                        step_phase = PH_WIDTH;
                    end
                    else if (pop_item.cls == CL_H)
                    begin
                        step_mask  = mask_reg | KM_SHORT;
                        step_mod   = MOD_SHORT;
                        step_phase = PH_TYPE;
                    end
                    else if (pop_item.cls == CL_L)
                    begin
                        step_mask  = mask_reg | KM_LONG;
                        step_mod   = MOD_LONG;
                        step_phase = PH_TYPE;
                    end
                    else if (pop_item.cls inside {CL_C, CL_U, CL_DI, CL_E, CL_G, CL_N,
                                                  CL_F, CL_O, CL_S, CL_BRACKET, CL_X})
                    begin
                        step_mask = mask_reg | KM_PLAIN;
                        step_mod  = MOD_NONE;
                        use_conv  = 1'b1;
                    end
                    else
                    begin
                        step_err = 1'b1;
                    end
                end
                default: step_err = 1'b1;
            endcase
            if (use_conv)
            begin
                cnt_down = conv.dec;
                if (conv.err)
                begin
                    step_err = 1'b1;
                end
                else
                begin
                    step_mask  = step_mask | conv.bits;
                    step_phase = conv.brk ? PH_BRACKET : PH_LITERAL;
                end
            end
        end

        if (cnt_up && cnt_reg != CNT_MAX)
            step_cnt = cnt_reg + CNT_W'(1);
        else if (cnt_down && cnt_reg != CNT_MIN)
            step_cnt = cnt_reg - CNT_W'(1);
        else
            step_cnt = cnt_reg;
    end

    // next state: clear after the last character of a string
    always_comb
    begin
        phase_next = phase_reg;
        mod_next   = mod_reg;
        cnt_next   = cnt_reg;
        mask_next  = mask_reg;
        err_next   = err_reg;
        if (fire)
        begin
            if (pop_item.last)
            begin
                phase_next = PH_LITERAL;
                mod_next   = MOD_NONE;
                cnt_next   = '0;
                mask_next  = '0;
                err_next   = 1'b0;
            end
            else
            begin
                phase_next = step_phase;
                mod_next   = step_mod;
                cnt_next   = step_cnt;
                mask_next  = step_mask;
                err_next   = step_err;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_cnt_next    = out_cnt_reg;
        out_mask_next   = out_mask_reg;
        if (fire && pop_item.last)
        begin
            out_valid_next = 1'b1;
            if (step_err)
                out_status_next = ST_BAD;
            else if (step_phase == PH_LITERAL || step_phase == PH_BRACKET)
                out_status_next = ST_OK;
            else
                out_status_next = ST_INCOMPLETE;
            out_cnt_next  = (out_status_next == ST_OK) ? step_cnt : '0;
            out_mask_next = step_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LITERAL;
            mod_reg       <= MOD_NONE;
            cnt_reg       <= '0;
            mask_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            mod_reg       <= mod_next;
            cnt_reg       <= cnt_next;
            mask_reg      <= mask_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_cnt_reg    <= out_cnt_next;
        out_mask_reg   <= out_mask_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.conversion_count = out_cnt_reg;
    assign rsp.kind_mask        = out_mask_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX && cnt_reg >= CNT_MIN)
        else $error("running count beyond limit");

    a_type_has_mod: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TYPE |-> mod_reg != MOD_NONE)
        else $error("type phase without modifier");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pop_item.last |=> out_valid_reg)
        else $error("last character produced no result");

    a_bad_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_cnt_reg == '0)
        else $error("count reported on failed format");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pop_item.last |=> phase_reg == PH_LITERAL && !err_reg && mask_reg == '0)
        else $error("state not cleared after last character");

endmodule
